### rtl/core/pls_pkg.sv
`default_nettype none

package pls_pkg;

	// Request codes carried on the operation field.
	typedef enum logic [3:0] {
		OP_INS_FRONT = 4'd0,
		OP_INS_BACK  = 4'd1,
		OP_INS_AT    = 4'd2,
		OP_RD_FRONT  = 4'd3,
		OP_RD_BACK   = 4'd4,
		OP_RD_AT     = 4'd5,
		OP_RM_FRONT  = 4'd6,
		OP_RM_BACK   = 4'd7,
		OP_RM_AT     = 4'd8
	} op_t;

	// Completion codes returned with every result.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// Width of the value fields on both channels.
	localparam int unsigned VALUE_W = 32;

endpackage

`default_nettype wire

### rtl/core/pls_ram.sv
`default_nettype none

module pls_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one read port; read data is registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/core/positional_list_store_unit.sv
// Positional list store: an ordered list of up to CAPACITY values held in one RAM.
// Requests arrive on the input channel (operation, value, position) and each one
// produces exactly one result (value_out, count_out, status) on the output channel.
// Both channels transfer when valid is high and stall is low at a rising clock edge.
// One request is worked on at a time; in_stall is high while a request is in progress.
// Steps per request: errors and unknown codes go straight to the finish state; reads
//   wait for the registered RAM data; an insert at position p first moves entries p..count-1
//   up, then writes the value at p; a remove at p reads it, then moves entries p+1..count-1 down.
// An insert or remove at the front is the worst case, because every element behind the
// position is moved through the RAM's single write port, one element per cycle.
// in_stall falls at the edge that raises out_valid, so the next request can be
// accepted at the following edge.
// The result register lets a new request be accepted while the previous result still
// waits; a request that finishes while out_stall holds the old result waits until it
// has been transferred.
// Reset (arst_n low) empties the list and drops any pending result. RAM contents
// are not cleared; only entries below the count are ever used.
`default_nettype none

module positional_list_store_unit #(
	parameter int unsigned CAPACITY   = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [3:0]                          operation,
	input  wire logic signed [pls_pkg::VALUE_W-1:0]  value,
	input  wire logic [$clog2(CAPACITY+1)-1:0]       position,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [pls_pkg::VALUE_W-1:0]       value_out,
	output logic [$clog2(CAPACITY+1)-1:0]            count_out,
	output logic [1:0]                               status
);

	import pls_pkg::*;

	localparam int unsigned ADDR_W = $clog2(CAPACITY);
	localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT_UP,
		S_INS_PUT,
		S_RD_WAIT,
		S_SHIFT_DN,
		S_FINISH
	} state_t;

	state_t                      state_q;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            p_q;
	logic [CNT_W-1:0]            cur_q;
	logic [DATA_WIDTH-1:0]       val_q;
	logic                        take_q;
	logic                        pend_s1;
	logic [ADDR_W-1:0]           wa_s1;
	status_t                     res_status_q;
	logic signed [VALUE_W-1:0]   res_value_q;
	logic                        out_valid_q;
	logic signed [VALUE_W-1:0]   value_out_q;
	logic [CNT_W-1:0]            count_out_q;
	status_t                     status_q;

	// Request decode signals.
	logic                        acc_ins;
	logic                        acc_rd;
	logic                        acc_take;
	logic [CNT_W-1:0]            acc_p;
	status_t                     acc_st;
	logic [CNT_W-1:0]            last;

	// RAM port signals.
	logic                        ram_we;
	logic [ADDR_W-1:0]           ram_waddr;
	logic [DATA_WIDTH-1:0]       ram_wdata;
	logic [ADDR_W-1:0]           ram_raddr;
	logic [DATA_WIDTH-1:0]       ram_rdata;
	logic signed [DATA_WIDTH-1:0] rd_signed;
	logic [CNT_W-1:0]            cur_dec;
	logic                        out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign value_out = value_out_q;
	assign count_out = count_out_q;
	assign status    = status_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign rd_signed = ram_rdata;
	assign cur_dec   = cur_q - CNT_W'(1);
	assign last      = (count_q != '0) ? count_q - CNT_W'(1) : '0;

	// Decode the request: target position and the status it will end with.
	always_comb begin
		acc_ins  = 1'b0;
		acc_rd   = 1'b0;
		acc_take = 1'b0;
		acc_p    = '0;
		unique case (op_t'(operation))
			OP_INS_FRONT: begin acc_ins = 1'b1; acc_p = '0; end
			OP_INS_BACK:  begin acc_ins = 1'b1; acc_p = count_q; end
			OP_INS_AT:    begin acc_ins = 1'b1; acc_p = position; end
			OP_RD_FRONT:  begin acc_rd = 1'b1; acc_p = '0; end
			OP_RD_BACK:   begin acc_rd = 1'b1; acc_p = last; end
			OP_RD_AT:     begin acc_rd = 1'b1; acc_p = position; end
			OP_RM_FRONT:  begin acc_rd = 1'b1; acc_take = 1'b1; acc_p = '0; end
			OP_RM_BACK:   begin acc_rd = 1'b1; acc_take = 1'b1; acc_p = last; end
			OP_RM_AT:     begin acc_rd = 1'b1; acc_take = 1'b1; acc_p = position; end
			default:      begin acc_p = '0; end
		endcase

		if (acc_ins) begin
			if (acc_p > count_q) begin
				acc_st = ST_RANGE;
			end else if (count_q == CNT_W'(CAPACITY)) begin
				acc_st = ST_FULL;
			end else begin
				acc_st = ST_OK;
			end
		end else if (acc_rd) begin
			if (count_q == '0) begin
				acc_st = ST_EMPTY;
			end else if (acc_p >= count_q) begin
				acc_st = ST_RANGE;
			end else begin
				acc_st = ST_OK;
			end
		end else begin
			acc_st = ST_RANGE;
		end
	end

	// RAM addressing for each state. Shifts read one entry ahead of the write.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wa_s1;
		ram_wdata = ram_rdata;
		ram_raddr = acc_p[ADDR_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				ram_raddr = acc_p[ADDR_W-1:0];
			end
			S_SHIFT_UP: begin
				ram_we    = pend_s1;
				ram_raddr = cur_dec[ADDR_W-1:0];
			end
			S_INS_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = p_q[ADDR_W-1:0];
				ram_wdata = val_q;
			end
			S_SHIFT_DN: begin
				ram_we    = pend_s1;
				ram_raddr = cur_q[ADDR_W-1:0];
			end
			S_RD_WAIT,
			S_FINISH: begin
				ram_we = 1'b0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	pls_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer, list count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			pend_s1      <= 1'b0;
			wa_s1        <= '0;
			out_valid_q  <= 1'b0;
			p_q          <= '0;
			cur_q        <= '0;
			val_q        <= '0;
			take_q       <= 1'b0;
			res_status_q <= ST_OK;
			res_value_q  <= '0;
			value_out_q  <= '0;
			count_out_q  <= '0;
			status_q     <= ST_OK;
		end else begin
			// A finishing request reloads the result register itself.
			if (out_valid_q && !out_stall && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						p_q          <= acc_p;
						val_q        <= DATA_WIDTH'(value);
						take_q       <= acc_take;
						res_status_q <= acc_st;
						res_value_q  <= '0;
						pend_s1      <= 1'b0;
						cur_q        <= count_q;
						if (acc_st != ST_OK) begin
							state_q <= S_FINISH;
						end else if (acc_ins) begin
							state_q <= S_SHIFT_UP;
						end else begin
							state_q <= S_RD_WAIT;
						end
					end
				end

				// Move entries p..count-1 up by one, from the back.
				S_SHIFT_UP: begin
					pend_s1 <= (cur_q != p_q);
					wa_s1   <= cur_q[ADDR_W-1:0];
					if (cur_q != p_q) begin
						cur_q <= cur_dec;
					end else begin
						state_q <= S_INS_PUT;
					end
				end

				S_INS_PUT: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_FINISH;
				end

				S_RD_WAIT: begin
					res_value_q <= VALUE_W'(rd_signed);
					if (take_q) begin
						cur_q   <= p_q + CNT_W'(1);
						pend_s1 <= 1'b0;
						state_q <= S_SHIFT_DN;
					end else begin
						state_q <= S_FINISH;
					end
				end

				// Move entries p+1..count-1 down by one, from the front.
				S_SHIFT_DN: begin
					pend_s1 <= (cur_q < count_q);
					wa_s1   <= cur_dec[ADDR_W-1:0];
					if (cur_q < count_q) begin
						cur_q <= cur_q + CNT_W'(1);
					end else begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_FINISH;
					end
				end

				S_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						value_out_q <= res_value_q;
						count_out_q <= count_q;
						status_q    <= res_status_q;
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
